// ===== rtl/perspective_project_clip_fade_macros.svh =====
// Assertion macros for the perspective projection block.
`ifndef PERSPECTIVE_PROJECT_CLIP_FADE_MACROS_SVH
`define PERSPECTIVE_PROJECT_CLIP_FADE_MACROS_SVH

// Implication in the same cycle, checked outside reset.
`define PPCF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle, checked outside reset.
`define PPCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ppcf_pkg.sv =====
// Shared constants for the perspective projection block.
package ppcf_pkg;

	localparam logic [2:0] REG_XY_GAIN   = 3'd0;
	localparam logic [2:0] REG_DEPTH_OFS = 3'd1;
	localparam logic [2:0] REG_NEAR      = 3'd2;
	localparam logic [2:0] REG_FAR       = 3'd3;
	localparam logic [2:0] REG_FADE_BASE = 3'd4;
	localparam logic [2:0] REG_FADE_MODE = 3'd5;
	localparam logic [2:0] REG_FADE_MIN  = 3'd6;
	localparam logic [2:0] REG_FADE_MAX  = 3'd7;

	localparam logic [2:0] FADE_OFF   = 3'd0;
	localparam logic [2:0] FADE_LIN_Z = 3'd1;
	localparam logic [2:0] FADE_SQ_Z  = 3'd2;
	localparam logic [2:0] FADE_LIN_R = 3'd3;
	localparam logic [2:0] FADE_SQ_R  = 3'd4;

	localparam logic [31:0] RST_XY_GAIN   = 32'd65536;
	localparam logic [31:0] RST_DEPTH_OFS = 32'd0;
	localparam logic [30:0] RST_NEAR      = 31'd16384;
	localparam logic [30:0] RST_FAR       = 31'd6553600;
	localparam logic [30:0] RST_FADE_BASE = 31'd65536;
	localparam logic [2:0]  RST_FADE_MODE = FADE_LIN_Z;
	localparam logic [31:0] RST_FADE_MIN  = 32'd32768;
	localparam logic [31:0] RST_FADE_MAX  = 32'd98304;

	localparam logic [15:0] SCR_ONE     = 16'h4000;
	localparam logic [15:0] SCR_NEG_ONE = 16'hC000;
	localparam logic [15:0] COL_FULL    = 16'h8000;
	localparam logic [31:0] FAC_CAP     = 32'hFFFF_FFFF;

	localparam int SCR_Q_W = 15;
	localparam int RAD_W   = 64;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int FAC_W   = 32;
	localparam int DLY_A   = ROOT_W;
	localparam int DLY_B   = ROOT_W - SCR_Q_W;
	localparam int DLY_C   = FAC_W;
	localparam int LAT     = 3 + ROOT_W + 1 + FAC_W + 3;

endpackage

// ===== rtl/perspective_project_clip_fade.sv =====
// Perspective projection of one point with depth clipping and distance fade.
// One point enters per clock unless the output stalls; the pipeline is built
// around the 32-stage square root (radius) followed by the 32-stage
// fade divider, with three stages ahead for offset, clamps and products and
// three behind for the squared factor, the factor clamps and colour scaling.
// The whole pipeline advances together: it stalls only while a result waits
// at the output and is not taken. Configuration must be written while idle.
module perspective_project_clip_fade import ppcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        pt_valid,
	output logic        pt_ready,
	input  logic [31:0] world_x,
	input  logic [31:0] world_y,
	input  logic [31:0] world_z,
	input  logic [15:0] in_red,
	input  logic [15:0] in_green,
	input  logic [15:0] in_blue,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [15:0] screen_x,
	output logic [15:0] screen_y,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue,
	output logic        was_clipped
);

	// configuration registers
	logic [31:0] xy_gain_q, depth_ofs_q, fade_min_q, fade_max_q;
	logic [30:0] near_q, far_q, fade_base_q;
	logic [2:0]  fade_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xy_gain_q   <= RST_XY_GAIN;
			depth_ofs_q <= RST_DEPTH_OFS;
			near_q      <= RST_NEAR;
			far_q       <= RST_FAR;
			fade_base_q <= RST_FADE_BASE;
			fade_mode_q <= RST_FADE_MODE;
			fade_min_q  <= RST_FADE_MIN;
			fade_max_q  <= RST_FADE_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_XY_GAIN:   xy_gain_q   <= cfg_data;
				REG_DEPTH_OFS: depth_ofs_q <= cfg_data;
				REG_NEAR:      near_q      <= cfg_data[30:0];
				REG_FAR:       far_q       <= cfg_data[30:0];
				REG_FADE_BASE: fade_base_q <= cfg_data[30:0];
				REG_FADE_MODE: fade_mode_q <= cfg_data[2:0];
				REG_FADE_MIN:  fade_min_q  <= cfg_data;
				REG_FADE_MAX:  fade_max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Mode decode; the user must keep the registers still while points are in flight (not enforced here).
	logic fade_on, fade_sq, fade_rad;
	assign fade_on  = (fade_mode_q == FADE_LIN_Z) || (fade_mode_q == FADE_SQ_Z) ||
	                  (fade_mode_q == FADE_LIN_R) || (fade_mode_q == FADE_SQ_R);
	assign fade_sq  = (fade_mode_q == FADE_SQ_Z) || (fade_mode_q == FADE_SQ_R);
	assign fade_rad = (fade_mode_q == FADE_LIN_R) || (fade_mode_q == FADE_SQ_R);

	// Advance every stage together; hold all of them while the output waits.
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !vld_q[LAT-1] || res_ready;
	assign pt_ready  = en;
	assign res_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pt_valid};
		end
	end

	// Stage 1: depth offset, near clamp then far clamp (far wins), magnitudes.
	logic [32:0] zsum, znear, zfar;
	logic        lt_near, gt_far;
	logic [30:0] zu;
	logic [31:0] magx, magy;

	always_comb begin
		zsum    = {world_z[31], world_z} + {depth_ofs_q[31], depth_ofs_q};
		lt_near = $signed(zsum) < $signed({2'b00, near_q});
		znear   = lt_near ? {2'b00, near_q} : zsum;
		gt_far  = $signed(znear) > $signed({2'b00, far_q});
		zfar    = gt_far ? {2'b00, far_q} : znear;
		// a depth left at zero or below counts as one LSB
		zu      = ($signed(zfar) <= 33'sd0) ? 31'd1 : zfar[30:0];
		magx    = world_x[31] ? (~world_x + 32'd1) : world_x;
		magy    = world_y[31] ? (~world_y + 32'd1) : world_y;
	end

	logic [30:0] zu_s1;
	logic        cz_s1, sgx_s1, sgy_s1;
	logic [31:0] magx_s1, magy_s1;
	logic [47:0] col_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			zu_s1   <= zu;
			cz_s1   <= lt_near | gt_far;
			sgx_s1  <= world_x[31];
			sgy_s1  <= world_y[31];
			magx_s1 <= magx;
			magy_s1 <= magy;
			col_s1  <= {in_red, in_green, in_blue};
		end
	end

	// Stage 2: gain products and the squares for the radius.
	logic [63:0] numx_s2, numy_s2, sqx_s2, sqy_s2, sqz_s2;
	logic [30:0] zu_s2;
	logic        cz_s2, sgx_s2, sgy_s2;
	logic [47:0] col_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s2 <= 64'(magx_s1) * 64'(xy_gain_q);
			numy_s2 <= 64'(magy_s1) * 64'(xy_gain_q);
			sqx_s2  <= 64'(magx_s1) * 64'(magx_s1);
			sqy_s2  <= 64'(magy_s1) * 64'(magy_s1);
			sqz_s2  <= 64'(zu_s1) * 64'(zu_s1);
			zu_s2   <= zu_s1;
			cz_s2   <= cz_s1;
			sgx_s2  <= sgx_s1;
			sgy_s2  <= sgy_s1;
			col_s2  <= col_s1;
		end
	end

	// Stage 3: screen clamp tests and the radius sum.
	logic [63:0] numx_s3, numy_s3, sum_s3;
	logic [30:0] zu_s3;
	logic        cx_s3, cy_s3, clip_s3, sgx_s3, sgy_s3;
	logic [47:0] col_s3;
	logic        cx, cy;

	assign cx = numx_s2 > 64'({zu_s2, 16'h0000});
	assign cy = numy_s2 > 64'({zu_s2, 16'h0000});

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s3 <= numx_s2;
			numy_s3 <= numy_s2;
			sum_s3  <= sqx_s2 + sqy_s2 + sqz_s2;
			zu_s3   <= zu_s2;
			cx_s3   <= cx;
			cy_s3   <= cy;
			clip_s3 <= cz_s2 | cx | cy;
			sgx_s3  <= sgx_s2;
			sgy_s3  <= sgy_s2;
			col_s3  <= col_s2;
		end
	end

	// Screen divide by 4*z; each quotient is only used when its coordinate is not clamped.
	logic [SCR_Q_W-1:0] qx, qy, qx_d, qy_d;

	ppcf_div_pipe #(.NUM_W(64), .DEN_W(33), .Q_W(SCR_Q_W)) u_divx (
		.clk(clk), .en(en), .num(numx_s3), .den({zu_s3, 2'b00}), .quo(qx)
	);
	ppcf_div_pipe #(.NUM_W(64), .DEN_W(33), .Q_W(SCR_Q_W)) u_divy (
		.clk(clk), .en(en), .num(numy_s3), .den({zu_s3, 2'b00}), .quo(qy)
	);
	ppcf_delay #(.W(2 * SCR_Q_W), .D(DLY_B)) u_dly_b (
		.clk(clk), .en(en), .din({qx, qy}), .dout({qx_d, qy_d})
	);

	// 3D radius.
	logic [ROOT_W-1:0] root;

	ppcf_sqrt_pipe #(.IN_W(RAD_W)) u_sqrt (
		.clk(clk), .en(en), .n(sum_s3), .root(root)
	);

	logic [30:0] zu_a;
	logic        cx_a, cy_a, clip_a, sgx_a, sgy_a;
	logic [47:0] col_a;

	ppcf_delay #(.W(84), .D(DLY_A)) u_dly_a (
		.clk(clk), .en(en),
		.din({zu_s3, cx_s3, cy_s3, clip_s3, sgx_s3, sgy_s3, col_s3}),
		.dout({zu_a, cx_a, cy_a, clip_a, sgx_a, sgy_a, col_a})
	);

	// Stage 36: fade distance, factor overflow test, final screen values.
	logic [31:0] fade_dist;
	logic [15:0] sxv, syv;

	always_comb begin
		if (fade_rad) begin
			fade_dist = (root == '0) ? 32'd1 : root;
		end else begin
			fade_dist = {1'b0, zu_a};
		end
		if (cx_a) begin
			sxv = sgx_a ? SCR_NEG_ONE : SCR_ONE;
		end else begin
			sxv = sgx_a ? 16'h0000 - 16'(qx_d) : 16'(qx_d);
		end
		if (cy_a) begin
			syv = sgy_a ? SCR_NEG_ONE : SCR_ONE;
		end else begin
			syv = sgy_a ? 16'h0000 - 16'(qy_d) : 16'(qy_d);
		end
	end

	logic [31:0] fade_dist_s36;
	logic        ovf_s36, clip_s36;
	logic [15:0] sx_s36, sy_s36;
	logic [47:0] col_s36;

	always_ff @(posedge clk) begin
		if (en) begin
			fade_dist_s36 <= fade_dist;
			// base*2^16 / distance reaches 2^32 exactly when base >= distance*2^16
			ovf_s36  <= 48'(fade_base_q) >= {fade_dist, 16'h0000};
			clip_s36 <= clip_a;
			sx_s36   <= sxv;
			sy_s36   <= syv;
			col_s36  <= col_a;
		end
	end

	logic [FAC_W-1:0] fq;

	ppcf_div_pipe #(.NUM_W(47), .DEN_W(32), .Q_W(FAC_W)) u_divf (
		.clk(clk), .en(en), .num({fade_base_q, 16'h0000}), .den(fade_dist_s36), .quo(fq)
	);

	logic [15:0] sx_c, sy_c;
	logic        clip_c, ovf_c;
	logic [47:0] col_c;

	ppcf_delay #(.W(82), .D(DLY_C)) u_dly_c (
		.clk(clk), .en(en),
		.din({sx_s36, sy_s36, clip_s36, ovf_s36, col_s36}),
		.dout({sx_c, sy_c, clip_c, ovf_c, col_c})
	);

	// Stage 69: cap the linear factor and square it.
	logic [31:0] f1;
	logic [31:0] f1_s69;
	logic [63:0] prod_s69;
	logic [15:0] sx_s69, sy_s69;
	logic        clip_s69;
	logic [47:0] col_s69;

	assign f1 = ovf_c ? FAC_CAP : fq;

	always_ff @(posedge clk) begin
		if (en) begin
			f1_s69   <= f1;
			prod_s69 <= 64'(f1) * 64'(f1);
			sx_s69   <= sx_c;
			sy_s69   <= sy_c;
			clip_s69 <= clip_c;
			col_s69  <= col_c;
		end
	end

	// Stage 70: pick and cap the squared factor, clamp to min then max.
	logic [31:0] f2, fmn, fmx;
	logic [31:0] f_s70;
	logic [15:0] sx_s70, sy_s70;
	logic        clip_s70;
	logic [47:0] col_s70;

	always_comb begin
		if (fade_sq) begin
			f2 = (prod_s69[63:48] != 16'h0000) ? FAC_CAP : prod_s69[47:16];
		end else begin
			f2 = f1_s69;
		end
		fmn = (f2 < fade_min_q) ? fade_min_q : f2;
		fmx = (fmn > fade_max_q) ? fade_max_q : fmn;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s70    <= fmx;
			sx_s70   <= sx_s69;
			sy_s70   <= sy_s69;
			clip_s70 <= clip_s69;
			col_s70  <= col_s69;
		end
	end

	// Stage 71: scale, saturate or blank each channel into the output register.
	logic [15:0] cr, cg, cb;
	logic [47:0] pr, pg, pb;
	logic [15:0] col_r, col_g, col_b;

	assign cr = col_s70[47:32];
	assign cg = col_s70[31:16];
	assign cb = col_s70[15:0];
	assign pr = 48'(cr) * 48'(f_s70);
	assign pg = 48'(cg) * 48'(f_s70);
	assign pb = 48'(cb) * 48'(f_s70);

	always_comb begin
		priority if (clip_s70) begin
			col_r = '0;
			col_g = '0;
			col_b = '0;
		end else if (fade_on) begin
			col_r = (pr[47:16] > 32'(COL_FULL)) ? COL_FULL : pr[31:16];
			col_g = (pg[47:16] > 32'(COL_FULL)) ? COL_FULL : pg[31:16];
			col_b = (pb[47:16] > 32'(COL_FULL)) ? COL_FULL : pb[31:16];
		end else begin
			col_r = (cr > COL_FULL) ? COL_FULL : cr;
			col_g = (cg > COL_FULL) ? COL_FULL : cg;
			col_b = (cb > COL_FULL) ? COL_FULL : cb;
		end
	end

	logic [15:0] sx_s71, sy_s71, red_s71, green_s71, blue_s71;
	logic        clip_s71;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s71    <= sx_s70;
			sy_s71    <= sy_s70;
			red_s71   <= col_r;
			green_s71 <= col_g;
			blue_s71  <= col_b;
			clip_s71  <= clip_s70;
		end
	end

	assign screen_x    = sx_s71;
	assign screen_y    = sy_s71;
	assign out_red     = red_s71;
	assign out_green   = green_s71;
	assign out_blue    = blue_s71;
	assign was_clipped = clip_s71;

`include "perspective_project_clip_fade_macros.svh"

	`PPCF_ASSERT_NOW(a_clip_blank, res_valid && was_clipped,
		out_red == 16'h0000 && out_green == 16'h0000 && out_blue == 16'h0000,
		"clipped point carries colour")
	`PPCF_ASSERT_NOW(a_col_range, res_valid,
		out_red <= COL_FULL && out_green <= COL_FULL && out_blue <= COL_FULL,
		"colour above full scale")
	`PPCF_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, $stable(vld_q),
		"pipeline moved while output stalled")

endmodule

// ===== rtl/ppcf_delay.sv =====
// Enabled delay line that keeps side data aligned with the long units.
module ppcf_delay import ppcf_pkg::*; #(
	parameter int W = 8,
	parameter int D = 4
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] dl_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			dl_q[0] <= din;
			for (int i = 1; i < D; i++) begin
				dl_q[i] <= dl_q[i-1];
			end
		end
	end

	assign dout = dl_q[D-1];

endmodule

// ===== rtl/ppcf_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ppcf_div_pipe import ppcf_pkg::*; #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 33,
	parameter int Q_W   = 15
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);

	localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [NUM_W-1:0] rem_q [Q_W];
	logic [DEN_W-1:0] den_q [Q_W];
	logic [Q_W-1:0]   quo_q [Q_W];

	for (genvar i = 0; i < Q_W; i++) begin : g_stg
		localparam int SH = Q_W - 1 - i;
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   quo_in;
		logic [CMP_W-1:0] rext;
		logic [CMP_W-1:0] dsh;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_rest
			assign rem_in = rem_q[i-1];
			assign den_in = den_q[i-1];
			assign quo_in = quo_q[i-1];
		end

		assign rext = CMP_W'(rem_in);
		assign dsh  = CMP_W'(den_in) << SH;
		assign ge   = rext >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? NUM_W'(rext - dsh) : rem_in;
				den_q[i] <= den_in;
				quo_q[i] <= quo_in | (Q_W'(ge) << SH);
			end
		end
	end

	assign quo = quo_q[Q_W-1];

endmodule

// ===== rtl/ppcf_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
module ppcf_sqrt_pipe import ppcf_pkg::*; #(
	parameter int IN_W = RAD_W
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   n,
	output logic [IN_W/2-1:0] root
);

	localparam int STG = IN_W / 2;

	logic [IN_W-1:0] n_q [STG];
	logic [IN_W-1:0] r_q [STG];

	for (genvar i = 0; i < STG; i++) begin : g_stg
		localparam logic [IN_W-1:0] BIT = IN_W'(1) << (IN_W - 2 - 2 * i);
		logic [IN_W-1:0] n_in;
		logic [IN_W-1:0] r_in;
		logic [IN_W-1:0] trial;
		logic            ge;

		if (i == 0) begin : g_first
			assign n_in = n;
			assign r_in = '0;
		end else begin : g_rest
			assign n_in = n_q[i-1];
			assign r_in = r_q[i-1];
		end

		assign trial = r_in + BIT;
		assign ge    = n_in >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				n_q[i] <= ge ? n_in - trial : n_in;
				r_q[i] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
			end
		end
	end

	assign root = r_q[STG-1][STG-1:0];

endmodule

// ===== tb/tb_perspective_project_clip_fade.sv =====
// Self-checking testbench for the perspective projection block with clip and fade.
module tb_perspective_project_clip_fade;
	import ppcf_pkg::*;

	// Fields of one point request.
	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} point_t;

	// Fields of one projected result.
	typedef struct packed {
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        clipped;
	} proj_t;

	localparam int CYCLE_LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        pt_valid;
	logic        pt_ready;
	logic [31:0] world_x, world_y, world_z;
	logic [15:0] in_red, in_green, in_blue;
	logic        res_valid;
	logic        res_ready;
	logic [15:0] screen_x, screen_y, out_red, out_green, out_blue;
	logic        was_clipped;

	perspective_project_clip_fade u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pt_valid(pt_valid), .pt_ready(pt_ready),
		.world_x(world_x), .world_y(world_y), .world_z(world_z),
		.in_red(in_red), .in_green(in_green), .in_blue(in_blue),
		.res_valid(res_valid), .res_ready(res_ready),
		.screen_x(screen_x), .screen_y(screen_y),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.was_clipped(was_clipped)
	);

	// Shadow copy of the configuration registers.
	logic [31:0] sh_gain;
	logic [31:0] sh_offset;
	logic [30:0] sh_near, sh_far, sh_base;
	logic [2:0]  sh_mode;
	logic [31:0] sh_fmin, sh_fmax;

	point_t pending_points[$];
	proj_t  expected_proj[$];
	int     mismatches;
	int     cycle_count;
	bit     calm;          // no idling while set
	bit     hold_sender;   // sender hold-off requested by the stimulus

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Integer square root, floor.
	function automatic logic [63:0] root_floor(input logic [127:0] n);
		logic [127:0] res, bitv, rem;
		res = 0;
		rem = n;
		bitv = 128'd1 << 126;
		while (bitv > rem) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[63:0];
	endfunction

	// Q2.14 projection of one coordinate; raise clip on clamp.
	function automatic logic [15:0] screen_coord(input logic signed [31:0] c,
			input logic [63:0] depth, inout bit clip);
		logic [63:0] mag, num, q;
		mag = c[31] ? 64'(-64'(c)) : 64'(c);
		num = mag * 64'(sh_gain);
		if (num > (depth << 16)) begin
			clip = 1;
			q = 64'(SCR_ONE);
		end else begin
			q = num / (depth * 4);
		end
		return c[31] ? 16'(-q) : 16'(q);
	endfunction

	function automatic logic [15:0] fade_channel(input logic [15:0] c, input logic [63:0] f);
		logic [63:0] v;
		v = (64'(c) * f) >> 16;
		return (v > 64'(COL_FULL)) ? COL_FULL : v[15:0];
	endfunction

	function automatic proj_t project_point(input point_t p);
		proj_t r;
		logic signed [63:0] z;
		logic [63:0] zu, ax, ay, fade_dist, f;
		logic [127:0] sum;
		bit clip;
		clip = 0;
		z = 64'($signed(p.pz)) + 64'($signed(sh_offset));
		if (z < $signed(64'(sh_near))) begin z = 64'(sh_near); clip = 1; end
		if (z > $signed(64'(sh_far))) begin z = 64'(sh_far); clip = 1; end
		zu = (z <= 0) ? 64'd1 : z;
		r.sx = screen_coord(p.px, zu, clip);
		r.sy = screen_coord(p.py, zu, clip);
		r.clipped = clip;
		if (clip) begin
			r.red = 0; r.green = 0; r.blue = 0;
		end else if (sh_mode >= FADE_LIN_Z && sh_mode <= FADE_SQ_R) begin
			fade_dist = zu;
			if (sh_mode >= FADE_LIN_R) begin
				ax = p.px[31] ? 64'(-64'($signed(p.px))) : 64'(p.px);
				ay = p.py[31] ? 64'(-64'($signed(p.py))) : 64'(p.py);
				sum = 128'(ax * ax) + 128'(ay * ay) + 128'(zu * zu);
				fade_dist = root_floor(sum);
				if (fade_dist == 0) fade_dist = 1;
			end
			f = (64'(sh_base) << 16) / fade_dist;
			if (f > 64'(FAC_CAP)) f = 64'(FAC_CAP);
			if (sh_mode == FADE_SQ_Z || sh_mode == FADE_SQ_R) begin
				f = (f * f) >> 16;
				if (f > 64'(FAC_CAP)) f = 64'(FAC_CAP);
			end
			if (f < 64'(sh_fmin)) f = 64'(sh_fmin);
			if (f > 64'(sh_fmax)) f = 64'(sh_fmax);
			r.red = fade_channel(p.red, f);
			r.green = fade_channel(p.green, f);
			r.blue = fade_channel(p.blue, f);
		end else begin
			r.red = (p.red > COL_FULL) ? COL_FULL : p.red;
			r.green = (p.green > COL_FULL) ? COL_FULL : p.green;
			r.blue = (p.blue > COL_FULL) ? COL_FULL : p.blue;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
		mismatches++;
	endtask

	// Driver: present queued requests, idle at random unless calm.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid <= 1'b0;
		end else begin
			if (pt_valid && pt_ready) begin
				expected_proj.push_back(project_point({world_x, world_y, world_z,
					in_red, in_green, in_blue}));
			end
			if (!pt_valid || pt_ready) begin
				if (pending_points.size() != 0 && !hold_sender
						&& (calm || $urandom_range(99) >= 15)) begin
					point_t p;
					p = pending_points.pop_front();
					pt_valid <= 1'b1;
					world_x <= p.px; world_y <= p.py; world_z <= p.pz;
					in_red <= p.red; in_green <= p.green; in_blue <= p.blue;
				end else begin
					pt_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: take results and compare them with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_proj.size() == 0) begin
					$display("unexpected result at cycle %0d", cycle_count);
					mismatches++;
				end else begin
					proj_t e;
					e = expected_proj.pop_front();
					if (screen_x !== e.sx) report_mismatch("screen_x", screen_x, e.sx);
					if (screen_y !== e.sy) report_mismatch("screen_y", screen_y, e.sy);
					if (out_red !== e.red) report_mismatch("out_red", out_red, e.red);
					if (out_green !== e.green)
						report_mismatch("out_green", out_green, e.green);
					if (out_blue !== e.blue) report_mismatch("out_blue", out_blue, e.blue);
					if (was_clipped !== e.clipped)
						report_mismatch("was_clipped", 16'(was_clipped), 16'(e.clipped));
				end
			end
			res_ready <= calm || ($urandom_range(99) >= 15);
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Write one register at a clock edge and track it in the shadow copy.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_XY_GAIN:   sh_gain = val;
			REG_DEPTH_OFS: sh_offset = val;
			REG_NEAR:      sh_near = val[30:0];
			REG_FAR:       sh_far = val[30:0];
			REG_FADE_BASE: sh_base = val[30:0];
			REG_FADE_MODE: sh_mode = val[2:0];
			REG_FADE_MIN:  sh_fmin = val;
			default:       sh_fmax = val;
		endcase
	endtask

	// Wait for every request to be taken and every result to arrive, then drain.
	task automatic drain;
		while (pending_points.size() != 0 || pt_valid || expected_proj.size() != 0)
			@(posedge clk);
		repeat (LAT + 10) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_colour;
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return COL_FULL;
			2: return 16'(32'($urandom));
			default: return 16'($urandom_range(32768));
		endcase
	endfunction

	// Coordinates mostly in a sensible range, sometimes at the extremes.
	function automatic logic [31:0] rand_coord(input bit depth);
		case ($urandom_range(7))
			0: return $urandom;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			default: begin
				if (depth) return $urandom_range(32'h0100_0000);
				return 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
			end
		endcase
	endfunction

	function automatic point_t rand_point;
		point_t p;
		p.px = rand_coord(0);
		p.py = rand_coord(0);
		p.pz = rand_coord(1);
		p.red = rand_colour();
		p.green = rand_colour();
		p.blue = rand_colour();
		return p;
	endfunction

	task automatic push_point(input logic [31:0] x, y, z, input logic [15:0] r, g, b);
		point_t p;
		p = '{px: x, py: y, pz: z, red: r, green: g, blue: b};
		pending_points.push_back(p);
	endtask

	task automatic random_config;
		write_reg(REG_XY_GAIN, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h4_0000));
		write_reg(REG_DEPTH_OFS, ($urandom_range(3) == 0) ? $urandom
			: 32'($signed($urandom_range(32'h20_0000)) - 32'sh10_0000));
		write_reg(REG_NEAR, $urandom_range(32'h2_0000, 1));
		write_reg(REG_FAR, ($urandom_range(5) == 0) ? $urandom_range(32'h7FFF_FFFF, 1)
			: $urandom_range(32'h100_0000, 32'h4_0000));
		write_reg(REG_FADE_BASE, ($urandom_range(5) == 0) ? $urandom_range(32'h7FFF_FFFF, 0)
			: $urandom_range(32'h8_0000, 1));
		write_reg(REG_FADE_MODE, $urandom_range(7));
		write_reg(REG_FADE_MIN, ($urandom_range(4) == 0) ? $urandom : $urandom_range(32'h1_0000));
		write_reg(REG_FADE_MAX, ($urandom_range(4) == 0) ? $urandom
			: $urandom_range(32'h4_0000, 32'h8000));
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = REG_XY_GAIN; cfg_data = 0;
		pt_valid = 1'b0; res_ready = 1'b0;
		world_x = 0; world_y = 0; world_z = 0;
		in_red = 0; in_green = 0; in_blue = 0;
		mismatches = 0; cycle_count = 0;
		calm = 0; hold_sender = 0;
		sh_gain = RST_XY_GAIN; sh_offset = RST_DEPTH_OFS; sh_near = RST_NEAR;
		sh_far = RST_FAR; sh_base = RST_FADE_BASE; sh_mode = RST_FADE_MODE;
		sh_fmin = RST_FADE_MIN; sh_fmax = RST_FADE_MAX;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (LAT + 5) @(posedge clk);

		// Directed: reset settings, extremes, depth below near and beyond far.
		push_point(0, 0, 32'h0001_0000, COL_FULL, 16'h4000, 0);
		push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_point(32'h0000_8000, 32'hFFFF_8000, 32'h8000_0000, COL_FULL, COL_FULL, COL_FULL);
		push_point(32'h0000_1000, 32'h0000_1000, 32'h7FFF_FFFF, COL_FULL, COL_FULL, COL_FULL);
		push_point(32'h0000_4000, 32'hFFFF_C000, 32'h0002_0000, 16'h8001, 16'h1234, 16'h7FFF);
		push_point(32'h0001_0000, 0, 32'h0001_0000, COL_FULL, 0, 0);
		drain();
		// Each fade mode, undefined modes included, with colours above full.
		for (int m = 0; m < 8; m++) begin
			write_reg(REG_FADE_MODE, 32'(m));
			push_point(32'h0000_3000, 32'hFFFF_D000, 32'h0000_C000, 16'hFFFF, COL_FULL, 16'h2000);
			push_point(32'h0000_0100, 32'h0000_0200, 32'h0010_0000, 16'h1000, 16'h8000, 16'h7000);
			drain();
		end
		// Far below near: far wins.
		write_reg(REG_NEAR, 32'h7FFF_FFFF);
		write_reg(REG_FAR, 32'd1);
		write_reg(REG_DEPTH_OFS, 32'h8000_0000);
		push_point(0, 0, 32'h8000_0000, COL_FULL, COL_FULL, COL_FULL);
		push_point(32'h0000_0001, 32'hFFFF_FFFF, 0, COL_FULL, COL_FULL, COL_FULL);
		drain();
		// Min above max, zero base distance, extreme gain.
		write_reg(REG_NEAR, 32'd1);
		write_reg(REG_FAR, 32'h7FFF_FFFF);
		write_reg(REG_DEPTH_OFS, 32'h7FFF_FFFF);
		write_reg(REG_XY_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_FADE_BASE, 0);
		write_reg(REG_FADE_MODE, FADE_SQ_R);
		write_reg(REG_FADE_MIN, 32'hFFFF_FFFF);
		write_reg(REG_FADE_MAX, 32'h0000_0000);
		push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, COL_FULL, COL_FULL, 16'hFFFF);
		push_point(0, 0, 0, 16'h0001, 16'h4000, COL_FULL);
		drain();
		write_reg(REG_XY_GAIN, 0);
		write_reg(REG_DEPTH_OFS, 0);
		write_reg(REG_FADE_BASE, 32'h7FFF_FFFF);
		write_reg(REG_FADE_MIN, 0);
		write_reg(REG_FADE_MAX, 32'hFFFF_FFFF);
		push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, COL_FULL, 16'h1111, 16'h0);
		push_point(32'h0000_0001, 32'h0000_0002, 32'h0000_0001, 16'h0001, 16'h0002, 16'h0003);
		drain();

		// Random phases, each with its own configuration.
		for (phase = 0; phase < 13; phase++) begin
			random_config();
			calm = (phase == 6);
			for (int i = 0; i < 100; i++) pending_points.push_back(rand_point());
			if (phase == 3) begin
				// Hold the sender until every expected result has come.
				while (pending_points.size() > 50) @(posedge clk);
				hold_sender = 1;
				while (pt_valid || expected_proj.size() != 0) @(posedge clk);
				hold_sender = 0;
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
